/* rtl/core/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and the round function of the streaming SHA-1 core.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ROUND_W     = 7;
  localparam logic [ROUND_W-1:0] LAST_LOAD_ROUND = 7'd15;
  localparam logic [ROUND_W-1:0] LAST_ROUND      = 7'd79;

  localparam logic [1:0] LAST_WORD_IDX = 2'd3;
  localparam logic [3:0] LEN_HI_WORD   = 4'd14;
  localparam logic [3:0] LEN_LO_WORD   = 4'd15;
  localparam logic [2:0] LAST_DIG_IDX  = 3'd4;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef logic [4:0][31:0] hash_t;

  localparam hash_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;
  } qentry_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

  function automatic hash_t sha1_round(input hash_t s, input logic [31:0] w,
                                       input logic [ROUND_W-1:0] r);
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;
    hash_t       n;
    if (r < 7'd20) begin
      f = (s[1] & s[2]) | (~s[1] & s[3]);
      k = K_0;
    end else if (r < 7'd40) begin
      f = s[1] ^ s[2] ^ s[3];
      k = K_1;
    end else if (r < 7'd60) begin
      f = (s[1] & s[2]) | (s[1] & s[3]) | (s[2] & s[3]);
      k = K_2;
    end else begin
      f = s[1] ^ s[2] ^ s[3];
      k = K_3;
    end
    t    = rotl(s[0], 5) + f + s[4] + k + w;
    n[0] = t;
    n[1] = s[0];
    n[2] = rotl(s[1], 30);
    n[3] = s[2];
    n[4] = s[3];
    return n;
  endfunction

endpackage

/* rtl/core/sha1_req_if.sv */
// ----------------------------------------------------------------------------
// sha1_req_if
// Request channel: at most one message byte with its flags per request.
// ----------------------------------------------------------------------------
interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

/* rtl/core/sha1_dig_if.sv */
// ----------------------------------------------------------------------------
// sha1_dig_if
// Digest channel: one 32-bit digest word per request.
// ----------------------------------------------------------------------------
interface sha1_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

/* rtl/core/sha1_front.sv */
// ----------------------------------------------------------------------------
// sha1_front
// Packs message bytes into big-endian words and generates the padding words.
// ----------------------------------------------------------------------------
module sha1_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha1_req_if.sink          req_i,
  input  logic              full_i,
  output logic              push_o,
  output sha1_pkg::qentry_t push_entry_o
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_ACC  = 3'b001,
    S_MARK = 3'b010,
    S_FILL = 3'b100
  } fstate_e;

  fstate_e      state_q, state_d;
  logic [31:0]  word_q, word_d;
  logic [1:0]   pos_q, pos_d;
  logic [3:0]   wcnt_q, wcnt_d;
  logic [60:0]  bcnt_q, bcnt_d;
  logic         len_ok_q, len_ok_d;
  logic         accept;
  logic [31:0]  mark_word;

  assign req_i.ready = (state_q == S_ACC) && !full_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    case (pos_q)
      2'd0:    mark_word = {PAD_MARK, 24'h0};
      2'd1:    mark_word = {word_q[7:0], PAD_MARK, 16'h0};
      2'd2:    mark_word = {word_q[15:0], PAD_MARK, 8'h0};
      default: mark_word = {word_q[23:0], PAD_MARK};
    endcase
  end

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    pos_d        = pos_q;
    wcnt_d       = wcnt_q;
    bcnt_d       = bcnt_q;
    len_ok_d     = len_ok_q;
    push_o       = 1'b0;
    push_entry_o = '{word: 32'h0, msg_end: 1'b0};
    case (state_q)
      S_ACC: begin
        if (accept) begin
          if (req_i.has_byte) begin
            word_d = {word_q[23:0], req_i.data_byte};
            pos_d  = pos_q + 2'd1;
            bcnt_d = bcnt_q + 61'd1;
            if (pos_q == LAST_WORD_IDX) begin
              push_o       = 1'b1;
              push_entry_o = '{word: word_d, msg_end: 1'b0};
              wcnt_d       = wcnt_q + 4'd1;
            end
          end
          if (req_i.last) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (!full_i) begin
          push_o       = 1'b1;
          push_entry_o = '{word: mark_word, msg_end: 1'b0};
          len_ok_d     = (wcnt_q != LEN_HI_WORD);
          pos_d        = 2'd0;
          wcnt_d       = wcnt_q + 4'd1;
          state_d      = S_FILL;
        end
      end
      S_FILL: begin
        if (!full_i) begin
          push_o = 1'b1;
          wcnt_d = wcnt_q + 4'd1;
          if (len_ok_q && wcnt_q == LEN_HI_WORD) begin
            push_entry_o = '{word: bcnt_q[60:29], msg_end: 1'b0};
          end else if (len_ok_q && wcnt_q == LEN_LO_WORD) begin
            push_entry_o = '{word: {bcnt_q[28:0], 3'b000}, msg_end: 1'b1};
            bcnt_d       = '0;
            len_ok_d     = 1'b0;
            state_d      = S_ACC;
          end else begin
            push_entry_o = '{word: 32'h0, msg_end: 1'b0};
            if (wcnt_q == LEN_LO_WORD) begin
              len_ok_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_ACC;
      pos_q    <= '0;
      wcnt_q   <= '0;
      bcnt_q   <= '0;
      len_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      wcnt_q   <= wcnt_d;
      bcnt_q   <= bcnt_d;
      len_ok_q <= len_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

/* rtl/core/sha1_queue.sv */
// ----------------------------------------------------------------------------
// sha1_queue
// Word queue between the packing front end and the compression back end.
// ----------------------------------------------------------------------------
module sha1_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sha1_pkg::qentry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output sha1_pkg::qentry_t entry_o
);
  import sha1_pkg::*;

  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  qentry_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/sha1_back.sv */
// ----------------------------------------------------------------------------
// sha1_back
// Runs 80 SHA-1 rounds per block, one per cycle while fed, and emits the digest.
// ----------------------------------------------------------------------------
module sha1_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sha1_pkg::qentry_t entry_i,
  output logic              pop_o,
  sha1_dig_if.source        dig_o
);
  import sha1_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_CALC = 4'b0010,
    S_SUM  = 4'b0100,
    S_OUT  = 4'b1000
  } bstate_e;

  bstate_e            state_q, state_d;
  hash_t              h_q, h_d;
  hash_t              v_q, v_d;
  logic [31:0]        w_q [16];
  logic [31:0]        w_t;
  logic [ROUND_W-1:0] rnd_q, rnd_d;
  logic [2:0]         idx_q, idx_d;
  logic               msg_q, msg_d;
  logic               step;
  logic               out_hs;

  assign pop_o  = (state_q == S_LOAD) && valid_i;
  assign out_hs = dig_o.valid && dig_o.ready;
  assign step   = pop_o || (state_q == S_CALC);

  assign dig_o.valid       = (state_q == S_OUT);
  assign dig_o.digest_word = h_q[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last_word   = (idx_q == LAST_DIG_IDX);

  always_comb begin
    if (state_q == S_LOAD) begin
      w_t = entry_i.word;
    end else begin
      w_t = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
    end
  end

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    v_d     = v_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    msg_d   = msg_q;
    case (state_q)
      S_LOAD: begin
        if (pop_o) begin
          v_d   = sha1_round(v_q, w_t, rnd_q);
          rnd_d = rnd_q + 7'd1;
          msg_d = entry_i.msg_end;
          if (rnd_q == LAST_LOAD_ROUND) begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        v_d = sha1_round(v_q, w_t, rnd_q);
        if (rnd_q == LAST_ROUND) begin
          rnd_d   = '0;
          state_d = S_SUM;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      S_SUM: begin
        for (int i = 0; i < 5; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        v_d = h_d;
        if (msg_q) begin
          idx_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_OUT: begin
        if (out_hs) begin
          if (idx_q == LAST_DIG_IDX) begin
            h_d     = H_INIT;
            v_d     = H_INIT;
            state_d = S_LOAD;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      h_q     <= H_INIT;
      v_q     <= H_INIT;
      rnd_q   <= '0;
      idx_q   <= '0;
      msg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      v_q     <= v_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      msg_q   <= msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_t;
    end
  end

`ifndef ASSERT_OFF
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= LAST_ROUND)
    else $error("round counter out of range");

  a_msg_end_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && entry_i.msg_end |-> rnd_q == LAST_LOAD_ROUND)
    else $error("message end word not at end of block");

  a_pop_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> rnd_q < 7'd16)
    else $error("queue read outside load rounds");

  a_digest_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && dig_o.last_word |=> (h_q == H_INIT) && (rnd_q == '0))
    else $error("chaining value not reinitialized after digest");
`endif

endmodule

/* rtl/core/sha1_hash_engine_core.sv */
// ----------------------------------------------------------------------------
// sha1_hash_engine_core
// Streaming SHA-1 hasher: message bytes in, five 32-bit digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per message byte (data_byte, has_byte) and the
//   flag last, which closes the message. has_byte low with last high closes
//   the message without a byte; both low is an idle request.
//   dig_o returns the digest as five words, index 0 (H0) first, last_word
//   set on index 4.
// Timing:
//   The front end takes one request per cycle while its 16-word queue has
//   room. The back end runs one round per cycle while it is not holding a
//   digest and has queue words for its load rounds: 80 rounds plus a sum step
//   per 64-byte block. Padding adds one or two blocks, and the front end takes
//   no request while it writes the padding words; the first digest word
//   appears once the back end has finished the rounds and the sum step of the
//   final block.
// Reset and stall:
//   Reset clears the queue, the counters and loads the initial hash value.
//   While dig_o is stalled the digest is held and the front end keeps taking
//   bytes of the next message until the queue fills.
// ----------------------------------------------------------------------------
module sha1_hash_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_req_if.sink   req_i,
  sha1_dig_if.source dig_o
);
  import sha1_pkg::*;

  logic    push, full, pop, q_valid;
  qentry_t push_entry, q_entry;

  sha1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  sha1_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .entry_o      (q_entry)
  );

  sha1_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (pop),
    .dig_o   (dig_o)
  );

endmodule
